// File: src/slist_pkg.sv
package slist_pkg;

    localparam logic [1:0] REQ_INSERT    = 2'd0;
    localparam logic [1:0] REQ_DELETE    = 2'd1;
    localparam logic [1:0] REQ_DUMP_ASC  = 2'd2;
    localparam logic [1:0] REQ_DUMP_DESC = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam int unsigned DATA_W = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_INS_HEAD,
        S_DELETE,
        S_DUMP
    } state_t;

endpackage

// File: src/slist_ram.sv
module slist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/sorted_list_engine.sv
// insert walks the entries down from the top and answers once it meets a smaller one or reaches
// entry zero; delete walks the whole list before it answers; dump strobes one result a cycle, one per entry
// throughput: one request at a time, the next taken in the cycle of the final result; entries
// are walked one per cycle through the one-read one-write entry ram
// full insert, empty delete, empty dump and insert into an empty list answer the cycle after accept
// rst_n clears the entry count and the controller, not the ram; results cannot be stalled
module sorted_list_engine #(
    parameter int CAPACITY = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       req_type,
    input  logic signed [slist_pkg::DATA_W-1:0] value,
    output logic                             result_strobe,
    output logic [1:0]                       status,
    output logic signed [slist_pkg::DATA_W-1:0] item,
    output logic                             last
);

    import slist_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    state_t state_reg, state_next;

    logic [CW-1:0]            count_reg, count_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic [AW-1:0]            issue_addr_reg, issue_addr_next;
    logic                     issue_more_reg, issue_more_next;
    logic                     down_reg, down_next;
    logic [AW-1:0]            last_addr_reg, last_addr_next;
    logic                     found_reg, found_next;
    logic                     data_valid_reg, data_valid_next;
    logic [AW-1:0]            data_tag_reg, data_tag_next;

    logic                     strobe_reg, strobe_next;
    logic [1:0]               status_reg, status_next;
    logic signed [DATA_W-1:0] item_reg, item_next;
    logic                     last_reg, last_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic          accept;
    logic          list_empty;
    logic          list_full;
    logic          immediate;
    logic          step_last;
    logic          ins_ge;
    logic          del_match;
    logic          issuing;
    logic [AW-1:0] top_addr;

    slist_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy          = (state_reg != S_IDLE);
    assign accept        = start && !busy;
    assign list_empty    = (count_reg == '0);
    assign list_full     = (count_reg == CW'(CAPACITY));
    assign top_addr      = AW'(count_reg - 1'b1);
    assign immediate     = list_empty || ((req_type == REQ_INSERT) && list_full);
    assign step_last     = data_valid_reg && (data_tag_reg == last_addr_reg);
    assign ins_ge        = ($signed(ram_rdata) >= value_reg);
    assign del_match     = (ram_rdata == value_reg);
    assign issuing       = issue_more_reg
                           && ((state_reg == S_INSERT) || (state_reg == S_DELETE)
                               || (state_reg == S_DUMP));
    assign ram_raddr     = issue_addr_reg;
    assign result_strobe = strobe_reg;
    assign status        = status_reg;
    assign item          = item_reg;
    assign last          = last_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && !immediate)
                begin
                    case (req_type)
                        REQ_INSERT: state_next = S_INSERT;
                        REQ_DELETE: state_next = S_DELETE;
                        default:    state_next = S_DUMP;
                    endcase
                end
            end
            S_INSERT:
            begin
                if (data_valid_reg)
                begin
                    if (!ins_ge)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (data_tag_reg == '0)
                    begin
                        state_next = S_INS_HEAD;
                    end
                end
            end
            S_INS_HEAD: state_next = S_IDLE;
            S_DELETE,
            S_DUMP:
            begin
                if (step_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next      = count_reg;
        value_next      = value_reg;
        issue_addr_next = issue_addr_reg;
        issue_more_next = issue_more_reg;
        down_next       = down_reg;
        last_addr_next  = last_addr_reg;
        found_next      = found_reg;
        data_valid_next = issuing;
        data_tag_next   = issue_addr_reg;
        strobe_next     = 1'b0;
        status_next     = status_reg;
        item_next       = item_reg;
        last_next       = last_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = value_reg;

        if (issuing)
        begin
            if (issue_addr_reg == last_addr_reg)
            begin
                issue_more_next = 1'b0;
            end
            else if (down_reg)
            begin
                issue_addr_next = issue_addr_reg - 1'b1;
            end
            else
            begin
                issue_addr_next = issue_addr_reg + 1'b1;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    value_next      = value;
                    found_next      = 1'b0;
                    issue_more_next = 1'b1;
                    down_next       = (req_type == REQ_INSERT) || (req_type == REQ_DUMP_DESC);
                    issue_addr_next = down_next ? top_addr : '0;
                    last_addr_next  = down_next ? '0 : top_addr;
                    if (immediate)
                    begin
                        strobe_next = 1'b1;
                        last_next   = 1'b1;
                        item_next   = value;
                        if ((req_type == REQ_INSERT) && list_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else if (req_type == REQ_INSERT)
                        begin
                            // empty list: the new value becomes entry zero
                            status_next = ST_OK;
                            ram_we      = 1'b1;
                            ram_waddr   = '0;
                            ram_wdata   = value;
                            count_next  = count_reg + 1'b1;
                        end
                        else
                        begin
                            status_next = ST_EMPTY;
                            if (req_type != REQ_DELETE)
                            begin
                                item_next = '0;
                            end
                        end
                    end
                end
            end
            S_INSERT:
            begin
                // walk down from the top, moving entries not smaller than the new value up one slot
                if (data_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = data_tag_reg + 1'b1;
                    if (ins_ge)
                    begin
                        ram_wdata = ram_rdata;
                    end
                    else
                    begin
                        ram_wdata   = value_reg;
                        count_next  = count_reg + 1'b1;
                        strobe_next = 1'b1;
                        status_next = ST_OK;
                        item_next   = value_reg;
                        last_next   = 1'b1;
                    end
                end
            end
            S_INS_HEAD:
            begin
                ram_we      = 1'b1;
                ram_waddr   = '0;
                ram_wdata   = value_reg;
                count_next  = count_reg + 1'b1;
                strobe_next = 1'b1;
                status_next = ST_OK;
                item_next   = value_reg;
                last_next   = 1'b1;
            end
            S_DELETE:
            begin
                // after the match every entry moves down one slot
                if (data_valid_reg)
                begin
                    found_next = found_reg || del_match;
                    if (found_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = data_tag_reg - 1'b1;
                        ram_wdata = ram_rdata;
                    end
                    if (step_last)
                    begin
                        strobe_next = 1'b1;
                        item_next   = value_reg;
                        last_next   = 1'b1;
                        if (found_reg || del_match)
                        begin
                            status_next = ST_OK;
                            count_next  = count_reg - 1'b1;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                end
            end
            S_DUMP:
            begin
                if (data_valid_reg)
                begin
                    strobe_next = 1'b1;
                    status_next = ST_OK;
                    item_next   = $signed(ram_rdata);
                    last_next   = step_last;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            issue_more_reg <= 1'b0;
            data_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            issue_more_reg <= issue_more_next;
            data_valid_reg <= data_valid_next;
            strobe_reg     <= strobe_next;
            found_reg      <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        issue_addr_reg <= issue_addr_next;
        down_reg       <= down_next;
        last_addr_reg  <= last_addr_next;
        data_tag_reg   <= data_tag_next;
        status_reg     <= status_next;
        item_reg       <= item_next;
        last_reg       <= last_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_last_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && last_reg |-> !busy)
        else $error("final result while still busy");

    a_run_only_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && !last_reg |-> state_reg == S_DUMP)
        else $error("non-final result outside a dump");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy || strobe_reg)
        else $error("accepted request neither running nor answered");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ({1'b0, ram_waddr} < (AW + 1)'(CAPACITY)))
        else $error("ram write beyond capacity");

endmodule
